/* design/sbir_pkg.sv */
// ----------------------------------------------------------------------------
// sbir_pkg
// Shared constants and types for the serial boot image receiver.
// ----------------------------------------------------------------------------
package sbir_pkg;

  // default width of the image memory address space
  localparam int unsigned ADDR_BITS_DFLT = 16;

  // reset value of the sync word, first expected byte in the low lane
  localparam logic [31:0] MAGIC_RESET = 32'h3233_5652;

  // receive phases
  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  // last byte position of a four-byte header field
  localparam logic [1:0] HDR_LAST = 2'd3;

  // one result per received byte
  typedef struct packed {
    logic [1:0]  phase_now;
    logic        led_on;
    logic        write_valid;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic        boot_now;
    logic        overflow;
  } result_t;

endpackage

/* design/sbir_core.sv */
// ----------------------------------------------------------------------------
// sbir_core
// Receive state machine: sync hunt, length capture and payload write
// sequencing. Updates its state on each accepted byte and presents the
// matching result combinationally.
// ----------------------------------------------------------------------------
module sbir_core #(
  parameter int unsigned ADDR_BITS = sbir_pkg::ADDR_BITS_DFLT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [7:0]        rx_byte,
  input  logic [31:0]       magic_word,
  output sbir_pkg::result_t res
);

  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  header_count_r, header_count_nxt;
  logic [31:0] image_length_r, image_length_nxt;
  logic [31:0] payload_index_r, payload_index_nxt;
  logic        led_r, led_nxt;

  logic [7:0]  want_byte;
  logic [31:0] len_merged;
  logic [31:0] index_inc;
  logic        in_range;

  // byte lane selects for the current header position
  assign want_byte  = magic_word[{header_count_r, 3'b000} +: 8];
  assign len_merged = image_length_r | ({24'd0, rx_byte} << {header_count_r, 3'b000});
  assign index_inc  = payload_index_r + 32'd1;
  assign in_range   = (payload_index_r >> ADDR_BITS) == 32'd0;

  // next state and result for one byte
  always_comb begin
    phase_nxt         = phase_r;
    header_count_nxt  = header_count_r;
    image_length_nxt  = image_length_r;
    payload_index_nxt = payload_index_r;
    led_nxt           = led_r;
    res               = '0;

    unique case (phase_r)
      sbir_pkg::PH_HUNT: begin
        if (rx_byte == want_byte) begin
          led_nxt = 1'b0;
          if (header_count_r == sbir_pkg::HDR_LAST) begin
            header_count_nxt = 2'd0;
            image_length_nxt = 32'd0;
            phase_nxt        = sbir_pkg::PH_LENGTH;
          end else begin
            header_count_nxt = header_count_r + 2'd1;
          end
        end else begin
          // mismatch: restart, byte is not retried as a first sync byte
          header_count_nxt = 2'd0;
          led_nxt          = 1'b1;
        end
      end
      sbir_pkg::PH_LENGTH: begin
        image_length_nxt = len_merged;
        if (header_count_r == sbir_pkg::HDR_LAST) begin
          header_count_nxt  = 2'd0;
          payload_index_nxt = 32'd0;
          // empty or negative image boots at once
          if ($signed(len_merged) <= 0) begin
            phase_nxt    = sbir_pkg::PH_DONE;
            res.boot_now = 1'b1;
          end else begin
            phase_nxt = sbir_pkg::PH_PAYLOAD;
          end
        end else begin
          header_count_nxt = header_count_r + 2'd1;
        end
      end
      sbir_pkg::PH_PAYLOAD: begin
        if (in_range) begin
          res.write_valid = 1'b1;
          res.write_addr  = payload_index_r[15:0];
          res.write_data  = rx_byte;
        end else begin
          res.overflow = 1'b1;
        end
        payload_index_nxt = index_inc;
        if (index_inc >= image_length_r) begin
          phase_nxt    = sbir_pkg::PH_DONE;
          res.boot_now = 1'b1;
        end
      end
      sbir_pkg::PH_DONE: begin
        // later bytes are ignored
      end
      default: begin
      end
    endcase

    res.phase_now = phase_nxt;
    res.led_on    = led_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= sbir_pkg::PH_HUNT;
      header_count_r  <= 2'd0;
      image_length_r  <= 32'd0;
      payload_index_r <= 32'd0;
      led_r           <= 1'b1;
    end else if (advance) begin
      phase_r         <= phase_nxt;
      header_count_r  <= header_count_nxt;
      image_length_r  <= image_length_nxt;
      payload_index_r <= payload_index_nxt;
      led_r           <= led_nxt;
    end
  end

endmodule

/* design/serial_boot_image_receiver.sv */
// ----------------------------------------------------------------------------
// serial_boot_image_receiver
// Hunts for a sync word on a serial byte stream, reads a signed little-endian
// image length and emits one memory write request per in-range payload byte.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------------
//  in      | input     | in_valid / in_ready   | in_rx_byte
//  out     | output    | out_valid / out_ready | phase, led, write, boot, overflow
//  cfg     | input     | cfg_valid / cfg_ready | cfg_data (sync word)
//
//  One byte per cycle while out_ready keeps up: the state update is a single
//  pass from the state registers into the output register, and a new request
//  can enter each cycle. Results show on out_* in the cycle after acceptance.
//  Synchronous reset returns to sync hunt with the led on; no clearing pass.
//  While a result waits, in_ready follows out_ready; cfg_ready is always high.
//
module serial_boot_image_receiver #(
  parameter int unsigned ADDR_BITS = sbir_pkg::ADDR_BITS_DFLT
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_phase_now,
  output logic        out_led_on,
  output logic        out_write_valid,
  output logic [15:0] out_write_addr,
  output logic [7:0]  out_write_data,
  output logic        out_boot_now,
  output logic        out_overflow,
  // sync word write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0]       magic_r;
  logic              out_valid_r;
  sbir_pkg::result_t out_r;
  sbir_pkg::result_t res;
  logic              accept;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // sync word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= sbir_pkg::MAGIC_RESET;
    end else if (cfg_valid) begin
      magic_r <= cfg_data;
    end
  end

  sbir_core #(
    .ADDR_BITS (ADDR_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (accept),
    .rx_byte    (in_rx_byte),
    .magic_word (magic_r),
    .res        (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_phase_now   = out_r.phase_now;
  assign out_led_on      = out_r.led_on;
  assign out_write_valid = out_r.write_valid;
  assign out_write_addr  = out_r.write_addr;
  assign out_write_data  = out_r.write_data;
  assign out_boot_now    = out_r.boot_now;
  assign out_overflow    = out_r.overflow;

  // a byte is either written or dropped, never both
  a_write_xor_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_write_valid && out_overflow))
    else $error("write and overflow flagged on the same byte");

  // results without a write request carry zero address and data
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_valid) |-> (out_write_addr == 16'd0 && out_write_data == 8'd0))
    else $error("address or data nonzero without a write");

  // boot only lands in the done phase
  a_boot_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_boot_now) |-> (out_phase_now == sbir_pkg::PH_DONE))
    else $error("boot raised outside the done phase");

  // writes only come from payload bytes
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_write_valid || out_overflow)) |->
      (out_phase_now == sbir_pkg::PH_PAYLOAD || out_phase_now == sbir_pkg::PH_DONE))
    else $error("write request outside payload reception");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for serial_boot_image_receiver. Bytes stream in through
// the valid/ready input; every accepted byte is run through a local model of
// the sync hunt, length header and payload writes, and each result that comes
// out is compared field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HUNT_SEGMENTS  = 6;
  localparam int unsigned SEGMENT_BYTES  = 250;
  localparam int unsigned TRAILING_BYTES = 16;
  localparam int unsigned PAYLOAD_CHUNK  = 100;

  // receiver state as the bench tracks it
  typedef struct packed {
    logic [1:0]  phase;
    logic [1:0]  hdr;
    logic [31:0] len;
    logic [31:0] idx;
    logic        led;
    logic [31:0] magic;
  } boot_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_phase_now;
  logic        out_led_on;
  logic        out_write_valid;
  logic [15:0] out_write_addr;
  logic [7:0]  out_write_data;
  logic        out_boot_now;
  logic        out_overflow;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = 32'h0;

  logic [7:0]  rx_byte_q [$];
  logic [31:0] sync_word_q [$];
  sbir_pkg::result_t due_result_q [$];

  boot_state_t pred_st;
  boot_state_t gen_st;
  sbir_pkg::result_t pred_res;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned fed_bytes = 0;

  // hand-picked hunt bytes against the reset sync word 52 56 33 32
  logic [7:0] hunt_directed [0:15] = '{
    8'h00, 8'hFF, 8'h52, 8'h52, 8'h52, 8'h56, 8'h33, 8'h33,
    8'h56, 8'h52, 8'h56, 8'h52, 8'h52, 8'h56, 8'h33, 8'h00
  };

  serial_boot_image_receiver uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_phase_now   (out_phase_now),
    .out_led_on      (out_led_on),
    .out_write_valid (out_write_valid),
    .out_write_addr  (out_write_addr),
    .out_write_data  (out_write_data),
    .out_boot_now    (out_boot_now),
    .out_overflow    (out_overflow),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  // clock and reset
  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic boot_state_t boot_reset();
    boot_state_t s;
    s       = '0;
    s.phase = sbir_pkg::PH_HUNT;
    s.led   = 1'b1;
    s.magic = sbir_pkg::MAGIC_RESET;
    return s;
  endfunction

  // one received byte: next state plus the result it produces
  function automatic boot_state_t next_boot_state(input boot_state_t s,
                                                  input logic [7:0] b,
                                                  output sbir_pkg::result_t r);
    boot_state_t n;
    n = s;
    r = '0;
    case (s.phase)
      sbir_pkg::PH_HUNT: begin
        if (b == s.magic[8*s.hdr +: 8]) begin
          n.led = 1'b0;
          if (s.hdr == sbir_pkg::HDR_LAST) begin
            n.hdr   = '0;
            n.len   = '0;
            n.phase = sbir_pkg::PH_LENGTH;
          end else begin
            n.hdr = s.hdr + 2'd1;
          end
        end else begin
          // mismatched byte is not retried as a first sync byte
          n.hdr = '0;
          n.led = 1'b1;
        end
      end
      sbir_pkg::PH_LENGTH: begin
        n.len = s.len | (32'(b) << (8*s.hdr));
        if (s.hdr == sbir_pkg::HDR_LAST) begin
          n.hdr = '0;
          n.idx = '0;
          if ($signed(n.len) <= 0) begin
            n.phase    = sbir_pkg::PH_DONE;
            r.boot_now = 1'b1;
          end else begin
            n.phase = sbir_pkg::PH_PAYLOAD;
          end
        end else begin
          n.hdr = s.hdr + 2'd1;
        end
      end
      sbir_pkg::PH_PAYLOAD: begin
        if ({1'b0, s.idx} < (33'd1 << sbir_pkg::ADDR_BITS_DFLT)) begin
          r.write_valid = 1'b1;
          r.write_addr  = s.idx[15:0];
          r.write_data  = b;
        end else begin
          r.overflow = 1'b1;
        end
        n.idx = s.idx + 32'd1;
        if (n.idx >= s.len) begin
          n.phase    = sbir_pkg::PH_DONE;
          r.boot_now = 1'b1;
        end
      end
      default: ;
    endcase
    r.phase_now = n.phase;
    r.led_on    = n.led;
    return n;
  endfunction

  // driver: byte and sync word requests, prediction at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
      pred_st   = boot_reset();
    end else begin
      if (cfg_valid && cfg_ready) pred_st.magic = cfg_data;
      if (in_valid && in_ready) begin
        pred_st = next_boot_state(pred_st, in_rx_byte, pred_res);
        due_result_q.push_back(pred_res);
      end
      if (!in_valid || in_ready) begin
        if (rx_byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid   <= 1'b1;
          in_rx_byte <= rx_byte_q.pop_front();
        end else begin
          in_valid   <= 1'b0;
          in_rx_byte <= 8'($urandom);
        end
      end
      if (!cfg_valid || cfg_ready) begin
        if (sync_word_q.size() != 0) begin
          cfg_valid <= 1'b1;
          cfg_data  <= sync_word_q.pop_front();
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // monitor: random backpressure, compare against the oldest prediction
  always @(posedge clk) begin
    sbir_pkg::result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_result_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = due_result_q.pop_front();
          check_field("phase_now", out_phase_now, want.phase_now);
          check_field("led_on", out_led_on, want.led_on);
          check_field("write_valid", out_write_valid, want.write_valid);
          check_field("write_addr", out_write_addr, want.write_addr);
          check_field("write_data", out_write_data, want.write_data);
          check_field("boot_now", out_boot_now, want.boot_now);
          check_field("overflow", out_overflow, want.overflow);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  task automatic push_rx_byte(input logic [7:0] b);
    sbir_pkg::result_t unused;
    gen_st = next_boot_state(gen_st, b, unused);
    rx_byte_q.push_back(b);
    fed_bytes++;
  endtask

  // hunt byte that never completes the sync word
  task automatic push_hunt_byte(input logic [7:0] b);
    boot_state_t       t;
    sbir_pkg::result_t unused;
    t = next_boot_state(gen_st, b, unused);
    if (t.phase != sbir_pkg::PH_HUNT) b = ~b;
    push_rx_byte(b);
  endtask

  // partial sync prefix, then a breaking byte (often the first sync byte)
  task automatic push_broken_sync();
    int unsigned k;
    logic [7:0]  b;
    k = $urandom_range(3);
    for (int i = 0; i < k; i++) push_hunt_byte(gen_st.magic[8*i +: 8]);
    b = $urandom_range(1) ? gen_st.magic[7:0] : 8'($urandom);
    push_hunt_byte(b);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (rx_byte_q.size() != 0 || in_valid || due_result_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_sync_word(input logic [31:0] w);
    wait_idle();
    sync_word_q.push_back(w);
    gen_st.magic = w;
    @(negedge clk);
    while (sync_word_q.size() != 0 || cfg_valid) @(negedge clk);
  endtask

  task automatic set_idling(input int unsigned step);
    case (step % 3)
      0: begin send_idle_pct = 37; recv_idle_pct = 65; end
      1: begin send_idle_pct = 65; recv_idle_pct = 37; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  // stimulus
  initial begin
    logic [31:0] sync_words [0:HUNT_SEGMENTS-1];
    logic [31:0] img_len;
    int unsigned seg_start;
    int unsigned pay_left;

    sync_words[0] = 32'h0000_0000;
    sync_words[1] = 32'hFFFF_FFFF;
    sync_words[2] = 32'h5252_5252;
    sync_words[3] = $urandom;
    sync_words[4] = $urandom;
    sync_words[5] = $urandom;
    gen_st = boot_reset();
    set_idling(0);
    @(negedge clk);
    while (!rst_n) @(negedge clk);

    // directed hunt against the reset sync word
    foreach (hunt_directed[i]) push_rx_byte(hunt_directed[i]);
    wait_idle();

    // random hunt under several sync words, idling pattern per pair
    for (int seg = 0; seg < HUNT_SEGMENTS; seg++) begin
      write_sync_word(sync_words[seg]);
      set_idling(seg / 2);
      seg_start = fed_bytes;
      while (fed_bytes - seg_start < SEGMENT_BYTES) begin
        if ($urandom_range(9) < 6) push_broken_sync();
        else push_hunt_byte(8'($urandom));
      end
    end
    wait_idle();

    // the block holds its done state until reset, so one run takes one ending
    set_idling(0);
    if (gen_st.hdr != 2'd0) push_rx_byte(~gen_st.magic[8*gen_st.hdr +: 8]);
    for (int i = 0; i < 4; i++) push_rx_byte(gen_st.magic[8*i +: 8]);
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0: img_len = 32'h0000_0000;
        1: img_len = 32'h8000_0000;
        2: img_len = 32'hFFFF_FFFF;
        default: img_len = {1'b1, 31'($urandom)};
      endcase
    end else begin
      // positive length, sent in chunks under each idling pattern
      img_len = 32'($urandom_range(200, 320));
    end
    for (int i = 0; i < 4; i++) push_rx_byte(img_len[8*i +: 8]);

    // payload: idling pattern over three chunks
    pay_left = ($signed(img_len) > 0) ? img_len : 0;
    for (int step = 0; step < 3 && pay_left != 0; step++) begin
      if (step != 0) begin
        wait_idle();
        set_idling(step);
      end
      for (int i = 0; i < ((step < 2 && pay_left > PAYLOAD_CHUNK) ? PAYLOAD_CHUNK : pay_left);
           i++)
        push_rx_byte(8'($urandom));
      pay_left = pay_left - ((step < 2 && pay_left > PAYLOAD_CHUNK) ? PAYLOAD_CHUNK : pay_left);
    end

    // bytes after completion are ignored
    for (int i = 0; i < TRAILING_BYTES; i++) push_rx_byte(8'($urandom));
    wait_idle();
    repeat (4) @(negedge clk);

    if (errors == 0 && due_result_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
